/* hw/rtl/epoch_to_calendar_date_assert.svh */
// Assertion macros shared by the epoch-to-calendar RTL.
`ifndef EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`define EPOCH_TO_CALENDAR_DATE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define E2CD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication.
`define E2CD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define E2CD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define E2CD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/e2cd_pkg.sv */
// Package: types, constants and calendar helpers for the epoch converter.
`timescale 1ns / 1ps
package e2cd_pkg;

  // Dividers for the time-of-day split
  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [16:0] SecPerMin  = 17'd60;

  // Rounded-up reciprocals of the odd part of each divider
  localparam logic [25:0] DayRecip  = 26'd50903317;  // 2^35 / 675, 86400 = 675 << 7
  localparam logic [13:0] HourRecip = 14'd9321;      // 2^21 / 225, 3600 = 225 << 4
  localparam logic [10:0] MinRecip  = 11'd1093;      // 2^14 / 15,  60 = 15 << 2

  // Each divide phase: a quotient step, then a remainder step
  localparam int DayCycles  = 2;
  localparam int HourCycles = 2;
  localparam int MinCycles  = 2;

  localparam logic [7:0] EpochYearOfs = 8'd70;   // 1970 - 1900
  localparam logic [7:0] Year2100Ofs  = 8'd200;  // only century in range that is not leap
  localparam logic [3:0] MonJan = 4'd0;
  localparam logic [3:0] MonFeb = 4'd1;
  localparam logic [3:0] MonApr = 4'd3;
  localparam logic [3:0] MonJun = 4'd5;
  localparam logic [3:0] MonSep = 4'd8;
  localparam logic [3:0] MonNov = 4'd10;
  localparam logic [3:0] MonDec = 4'd11;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_DIV,
    OP_END_DAY,
    OP_END_HOUR,
    OP_END_MIN,
    OP_YEAR,
    OP_MONTH
  } op_e;

  typedef enum logic [1:0] {
    DSEL_DAY,
    DSEL_HOUR,
    DSEL_MIN
  } dsel_e;

  typedef struct packed {
    op_e   op;
    dsel_e dsel;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } status_t;

  function automatic logic is_leap(input logic [7:0] yofs);
    return (yofs[1:0] == 2'b00) && (yofs != Year2100Ofs);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    if (mon == MonFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (mon inside {MonApr, MonJun, MonSep, MonNov}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

/* hw/rtl/epoch_to_calendar_date.sv */
// Top level: seconds-since-1970 to broken-down UTC calendar date converter.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  ---------------------------------------------
//  request   start, busy               epoch_seconds_i
//  result    result_valid_o (strobe)   second/minute/hour, year, day of year,
//                                      month, day of month
//
// A request transfers on a rising edge with start high and busy low.
// Time of day comes first: a reciprocal-multiply quotient step and a
// remainder step each for days, hours and minutes. Then the year walk steps
// once per year from 1970 until the remaining days fit the year, then the
// month walk steps once per month; busy spans all of them; the year walk dominates.
// busy is high from the transfer until the cycle the result strobe rises;
// a new request may transfer during the strobe cycle.
// The result is shown for one cycle only; the receiver cannot stall it.
// Reset clears the controller; datapath registers need no reset.
`timescale 1ns / 1ps
module epoch_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds_i,
  output logic        result_valid_o,
  output logic [5:0]  second_of_minute_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [4:0]  hour_of_day_o,
  output logic [7:0]  years_since_1900_o,
  output logic [8:0]  day_of_year_o,
  output logic [3:0]  month_index_o,
  output logic [4:0]  day_of_month_o
);
  import e2cd_pkg::*;

  // Command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // Sequencer: owns the handshake and the result strobe
  e2cd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (result_valid_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  // Datapath: divide, walk years, walk months, hold the result fields
  e2cd_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .epoch_seconds_i    (epoch_seconds_i),
    .second_of_minute_o (second_of_minute_o),
    .minute_of_hour_o   (minute_of_hour_o),
    .hour_of_day_o      (hour_of_day_o),
    .years_since_1900_o (years_since_1900_o),
    .day_of_year_o      (day_of_year_o),
    .month_index_o      (month_index_o),
    .day_of_month_o     (day_of_month_o)
  );

endmodule

/* hw/rtl/e2cd_dpath.sv */
// Datapath: reciprocal-multiply divider, year and month walkers, result registers.
`timescale 1ns / 1ps
`include "epoch_to_calendar_date_assert.svh"
module e2cd_dpath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  e2cd_pkg::cmd_t   cmd_i,
  output e2cd_pkg::status_t status_o,
  input  logic [31:0]      epoch_seconds_i,
  output logic [5:0]       second_of_minute_o,
  output logic [5:0]       minute_of_hour_o,
  output logic [4:0]       hour_of_day_o,
  output logic [7:0]       years_since_1900_o,
  output logic [8:0]       day_of_year_o,
  output logic [3:0]       month_index_o,
  output logic [4:0]       day_of_month_o
);
  import e2cd_pkg::*;

  logic [31:0] num_q;
  logic [15:0] quo_q, quo_n;
  logic [15:0] days_q;
  logic [7:0]  year_q;
  logic [3:0]  mon_q;
  logic [8:0]  yday_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q, dom_q;
  logic [16:0] divisor;
  logic [24:0] mul_a;
  logic [25:0] mul_b;
  logic [50:0] prod;
  logic [31:0] back;
  logic [31:0] remainder;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;

  // Drop the divider's power-of-two factor, then multiply by the reciprocal
  // of the odd part
  always_comb begin
    case (cmd_i.dsel)
      DSEL_DAY: begin
        divisor = SecPerDay;
        mul_a   = num_q[31:7];
        mul_b   = DayRecip;
      end
      DSEL_HOUR: begin
        divisor = SecPerHour;
        mul_a   = {12'd0, num_q[16:4]};
        mul_b   = {12'd0, HourRecip};
      end
      DSEL_MIN: begin
        divisor = SecPerMin;
        mul_a   = {15'd0, num_q[11:2]};
        mul_b   = {15'd0, MinRecip};
      end
      default: begin
        divisor = SecPerMin;
        mul_a   = {15'd0, num_q[11:2]};
        mul_b   = {15'd0, MinRecip};
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (cmd_i.dsel)
      DSEL_DAY:  quo_n = prod[50:35];
      DSEL_HOUR: quo_n = {11'd0, prod[25:21]};
      DSEL_MIN:  quo_n = {10'd0, prod[19:14]};
      default:   quo_n = {10'd0, prod[19:14]};
    endcase
  end

  // Remainder from the registered quotient
  assign back      = {16'd0, quo_q} * {15'd0, divisor};
  assign remainder = num_q - back;

  assign leap = is_leap(year_q);
  assign ylen = year_len(leap);
  assign mlen = month_len(mon_q, leap);

  assign status_o.year_done  = days_q < {7'd0, ylen};
  assign status_o.month_done = (mon_q == MonDec) || (days_q < {11'd0, mlen});

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        num_q <= epoch_seconds_i;
      end
      OP_DIV: begin
        quo_q <= quo_n;
      end
      OP_END_DAY: begin
        days_q <= quo_q;
        num_q  <= remainder;
      end
      OP_END_HOUR: begin
        hour_q <= quo_q[4:0];
        num_q  <= remainder;
      end
      OP_END_MIN: begin
        min_q  <= quo_q[5:0];
        sec_q  <= remainder[5:0];
        year_q <= EpochYearOfs;
      end
      OP_YEAR: begin
        if (status_o.year_done) begin
          yday_q <= days_q[8:0];
          mon_q  <= MonJan;
        end else begin
          days_q <= days_q - {7'd0, ylen};
          year_q <= year_q + 8'd1;
        end
      end
      OP_MONTH: begin
        if (status_o.month_done) begin
          dom_q <= days_q[4:0] + 5'd1;
        end else begin
          days_q <= days_q - {11'd0, mlen};
          mon_q  <= mon_q + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign years_since_1900_o = year_q;
  assign day_of_year_o      = yday_q;
  assign month_index_o      = mon_q;
  assign day_of_month_o     = dom_q;

  `E2CD_ASSERT_IMP(a_hour_fits, clk_i, rst_ni, cmd_i.op == OP_END_HOUR, quo_q[15:5] == 11'd0)
  `E2CD_ASSERT_IMP(a_month_range, clk_i, rst_ni, cmd_i.op == OP_MONTH,
                   (mon_q <= MonDec) && (days_q < 16'd366))
  `E2CD_ASSERT_IMP(a_min_fits, clk_i, rst_ni, cmd_i.op == OP_END_MIN, quo_q[15:6] == 10'd0)
  `E2CD_ASSERT_IMP(a_rem_fits, clk_i, rst_ni,
                   (cmd_i.op == OP_END_DAY) || (cmd_i.op == OP_END_HOUR) || (cmd_i.op == OP_END_MIN),
                   remainder < {15'd0, divisor})

endmodule

/* hw/rtl/e2cd_ctrl.sv */
// Controller: sequences the divide phases, the year walk and the month walk.
`timescale 1ns / 1ps
`include "epoch_to_calendar_date_assert.svh"
module e2cd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  output e2cd_pkg::cmd_t    cmd_o,
  input  e2cd_pkg::status_t status_i
);
  import e2cd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_YEAR,
    S_MONTH
  } state_e;

  state_e     state_q;
  logic [3:0] cnt_q;
  logic       done_q;
  logic       last;

  assign last   = (cnt_q == 4'd0);
  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    cmd_o.dsel = DSEL_DAY;
    cmd_o.op   = OP_IDLE;
    case (state_q)
      S_IDLE:  cmd_o.op = start_i ? OP_LOAD : OP_IDLE;
      S_DAY:   cmd_o.op = last ? OP_END_DAY : OP_DIV;
      S_HOUR: begin
        cmd_o.dsel = DSEL_HOUR;
        cmd_o.op   = last ? OP_END_HOUR : OP_DIV;
      end
      S_MIN: begin
        cmd_o.dsel = DSEL_MIN;
        cmd_o.op   = last ? OP_END_MIN : OP_DIV;
      end
      S_YEAR:  cmd_o.op = OP_YEAR;
      S_MONTH: cmd_o.op = OP_MONTH;
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == S_MONTH) && status_i.month_done;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_DAY;
            cnt_q   <= 4'(DayCycles - 1);
          end
        end
        S_DAY: begin
          if (last) begin
            state_q <= S_HOUR;
            cnt_q   <= 4'(HourCycles - 1);
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_HOUR: begin
          if (last) begin
            state_q <= S_MIN;
            cnt_q   <= 4'(MinCycles - 1);
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_MIN: begin
          if (last) begin
            state_q <= S_YEAR;
          end else begin
            cnt_q <= cnt_q - 4'd1;
          end
        end
        S_YEAR: begin
          if (status_i.year_done) begin
            state_q <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (status_i.month_done) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `E2CD_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, !busy_o)
  `E2CD_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q)
  `E2CD_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_q)

endmodule
